FILE: src/swa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

    // Register field widths
    localparam int KIND_W     = 4;
    localparam int FLEN_W     = 13;
    localparam int PHASE_W    = 24;
    localparam int TSCALE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Fixed-point widths
    localparam int COS_W    = 17;           // quarter-wave entry, 0..65536
    localparam int COEF_W   = 18;           // signed cosine-sum coefficient
    localparam int WGT_W    = 20;           // signed Q3.16 weight
    localparam int ACC_W    = 37;           // cosine-sum accumulator, signed Q4.32
    localparam int Q_SH     = 16;
    localparam int ONE_Q16  = 65536;
    localparam int N_TERMS  = 4;            // cosine harmonics after the constant term

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [KIND_W-1:0] {
        WK_PASS,
        WK_TRI,
        WK_BARTLETT,
        WK_WELCH,
        WK_HANN,
        WK_BLACKMAN,
        WK_EXACT,
        WK_NUTTALL,
        WK_BL_NUTTALL,
        WK_BL_HARRIS,
        WK_FLATTOP
    } t_window_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND,
        CFG_LENGTH,
        CFG_STEP,
        CFG_TSCALE
    } t_cfg_reg;

    typedef logic signed [COEF_W-1:0] t_coef_row [N_TERMS];

    // Constant term of the cosine sum, Q16
    function automatic logic [COS_W-1:0] f_cos_a0(input logic [KIND_W-1:0] kind);
        logic [COS_W-1:0] a0;
        unique case (kind)
            WK_HANN:       a0 = 17'd32768;
            WK_BLACKMAN:   a0 = 17'd27525;
            WK_EXACT:      a0 = 17'd27957;
            WK_NUTTALL:    a0 = 17'd23316;
            WK_BL_NUTTALL: a0 = 17'd23828;
            WK_BL_HARRIS:  a0 = 17'd23511;
            WK_FLATTOP:    a0 = 17'd65536;
            default:       a0 = '0;
        endcase
        return a0;
    endfunction

    // Harmonic coefficients with the alternating sign folded in
    function automatic logic signed [COEF_W-1:0] f_cos_coef(
        input logic [KIND_W-1:0] kind,
        input logic [1:0]        term
    );
        t_coef_row row;
        unique case (kind)
            WK_HANN:       row = '{-18'sd32768,  18'sd0,     18'sd0,     18'sd0};
            WK_BLACKMAN:   row = '{-18'sd32768,  18'sd5243,  18'sd0,     18'sd0};
            WK_EXACT:      row = '{-18'sd32543,  18'sd5036,  18'sd0,     18'sd0};
            WK_NUTTALL:    row = '{-18'sd31942,  18'sd9452, -18'sd826,   18'sd0};
            WK_BL_NUTTALL: row = '{-18'sd32059,  18'sd8952, -18'sd697,   18'sd0};
            WK_BL_HARRIS:  row = '{-18'sd32001,  18'sd9259, -18'sd765,   18'sd0};
            WK_FLATTOP:    row = '{-18'sd126484, 18'sd84541, -18'sd25428, 18'sd1835};
            default:       row = '{default: '0};
        endcase
        return row[term];
    endfunction

endpackage

`default_nettype wire

FILE: src/swa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface swa_sample_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface swa_result_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS+2:0] sample_out;
    logic                          frame_end;

    modport source (output valid, output sample_out, output frame_end, input ready);
    modport sink   (input valid, input sample_out, input frame_end, output ready);
endinterface

interface swa_cfg_if
    import swa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/swa_cos_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module swa_cos_rom
    import swa_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic      [COS_W-1:0]           o_data
);

    typedef logic [COS_W-1:0] t_cos_lut [DEPTH];

    // cos(pi/2 * i / DEPTH) in Q16 by a Q30 Taylor series to theta^12
    function automatic t_cos_lut f_build_lut();
        t_cos_lut lut;
        longint   th;
        longint   t2;
        longint   r;
        longint   q;
        for (int i = 0; i < DEPTH; i++) begin
            th = (HALF_PI_Q30 * longint'(i)) / DEPTH;
            t2 = (th * th) >>> 30;
            r  = longint'(1) <<< 30;
            for (int k = 0; k < 6; k++) begin
                q = (t2 * r) >>> 30;
                unique case (k)
                    0:       q = q / 132;
                    1:       q = q / 90;
                    2:       q = q / 56;
                    3:       q = q / 30;
                    4:       q = q / 12;
                    default: q = q / 2;
                endcase
                r = (longint'(1) <<< 30) - q;
            end
            if (r < 0) begin
                r = 0;
            end
            lut[i] = COS_W'((r + 8192) >>> 14);
        end
        return lut;
    endfunction

    localparam t_cos_lut COS_LUT = f_build_lut();

    logic [COS_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= COS_LUT[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: src/spectral_window_applier.sv
`timescale 1ns / 1ps
`default_nettype none

// Spectral window applier: scales each audio sample by the window weight of
// its place in a frame.
//
// Channels: i_cfg writes the window kind, frame length, phase step and
// triangle scale by register index; it is always ready and must only be used
// while the block is idle. i_in carries one signed sample a beat; o_out
// returns the rounded, saturated product and a flag on the last sample of
// each frame.
//
// Sequencing: one shared multiplier serves every product under a small
// sequencer, so a sample occupies the block until its result is offered:
// pass-through and Bartlett go straight to the sample multiply, triangular
// and Welch take one extra multiply for the weight, and cosine sums stream
// four harmonics through the registered quarter-wave table and the
// multiplier one per cycle. No new input beat is taken while a sample is in
// work; when the result is offered, i_in is ready again in that same cycle.
//
// Reset clears position and phase and restores the register defaults.
// A stalled receiver holds the result in the output register; one more sample
// is taken and worked, then waits until the output register frees.
module spectral_window_applier
    import swa_pkg::*;
#(
    parameter int MAX_FRAME       = 4096,
    parameter int COS_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS     = 24
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    swa_cfg_if.sink        i_cfg,
    swa_sample_if.sink     i_in,
    swa_result_if.source   o_out
);

    localparam int POS_W  = $clog2(MAX_FRAME);
    localparam int CW     = (FLEN_W > POS_W + 1) ? FLEN_W : POS_W + 1;
    localparam int IW     = $clog2(COS_TABLE_DEPTH + 1);
    localparam int AW     = $clog2(COS_TABLE_DEPTH);
    localparam int FRAC_W = PHASE_W - 2;
    localparam int SC_W   = IW + FRAC_W;
    localparam int T_W    = PHASE_W + 1;
    localparam int MA     = (SAMPLE_BITS > T_W + 1) ? SAMPLE_BITS : T_W + 1;
    localparam int MB     = T_W + 1;
    localparam int PW     = MA + MB;
    localparam int OW     = SAMPLE_BITS + 3;

    localparam longint SAT_HI = 5 * (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -5 * (longint'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [PW-1:0] SAT_HI_P = PW'(SAT_HI);
    localparam logic signed [PW-1:0] SAT_LO_P = PW'(SAT_LO);
    localparam logic signed [OW-1:0] OUT_HI   = OW'(SAT_HI);
    localparam logic signed [OW-1:0] OUT_LO   = OW'(SAT_LO);
    localparam logic [1:0]           TERM_LAST = 2'(N_TERMS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TMUL,
        S_TWGT,
        S_COS,
        S_SMUL,
        S_ROUND
    } t_state;

    // Control registers
    t_state                  r_state,     n_state;
    logic [KIND_W-1:0]       r_kind,      n_kind;
    logic [FLEN_W-1:0]       r_flen,      n_flen;
    logic [PHASE_W-1:0]      r_step,      n_step;
    logic [TSCALE_W-1:0]     r_tscale,    n_tscale;
    logic [POS_W-1:0]        r_pos,       n_pos;
    logic [PHASE_W-1:0]      r_phacc,     n_phacc;
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_iss,       n_iss;
    logic                    r_s1_v,      n_s1_v;
    logic                    r_s2_v,      n_s2_v;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] r_sample,     n_sample;
    logic [T_W-1:0]                r_t,          n_t;
    logic [PHASE_W-1:0]            r_ph,         n_ph;
    logic [PHASE_W-1:0]            r_cph,        n_cph;
    logic                          r_last,       n_last;
    logic [1:0]                    r_s1_k,       n_s1_k;
    logic                          r_s1_neg,     n_s1_neg;
    logic                          r_s1_zero,    n_s1_zero;
    logic [1:0]                    r_s2_k,       n_s2_k;
    logic signed [PW-1:0]          r_prod,       n_prod;
    logic signed [ACC_W-1:0]       r_acc,        n_acc;
    logic signed [WGT_W-1:0]       r_weight,     n_weight;
    logic signed [OW-1:0]          r_out_sample, n_out_sample;
    logic                          r_out_end,    n_out_end;

    // Combinational helpers
    logic                    w_in_fire;
    logic                    w_cfg_fire;
    logic [CW-1:0]           w_flen;
    logic [CW-1:0]           w_len;
    logic [CW-1:0]           w_pos1;
    logic                    w_last;
    logic [T_W-1:0]          w_t;
    logic [T_W:0]            w_tb;
    logic signed [WGT_W-1:0] w_bart;
    logic signed [ACC_W-1:0] w_acc_init;
    logic [1:0]              w_quad;
    logic [FRAC_W-1:0]       w_frac;
    logic [SC_W-1:0]         w_scaled;
    logic [IW-1:0]           w_idx;
    logic [IW-1:0]           w_mir;
    logic [IW-1:0]           w_sel;
    logic                    w_zero;
    logic [AW-1:0]           w_rom_addr;
    logic [COS_W-1:0]        w_rom_data;
    logic signed [COS_W:0]   w_cos;
    logic signed [MA-1:0]    w_mul_a;
    logic signed [MB-1:0]    w_mul_b;
    logic signed [PW-1:0]    w_mul;
    logic [PW-1:0]           w_tsum;
    logic [PW-1:0]           w_wsum;
    logic signed [PW-1:0]    w_rsum;
    logic signed [PW-1:0]    w_y;
    logic signed [OW-1:0]    w_y_sat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_cfg_fire  = i_cfg.valid;
    assign w_in_fire   = i_in.valid && (r_state == S_IDLE);

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.frame_end  = r_out_end;

    // Frame bookkeeping: clamp the length, flag the last index
    always_comb begin
        w_flen = CW'(r_flen);
        if (w_flen < CW'(2)) begin
            w_len = CW'(2);
        end else if (w_flen > CW'(MAX_FRAME)) begin
            w_len = CW'(MAX_FRAME);
        end else begin
            w_len = w_flen;
        end
        w_pos1 = CW'(r_pos) + CW'(1);
        w_last = (w_pos1 >= w_len);
    end

    // Distance from frame centre, |2*phase - 2^24|, and the Bartlett weight
    always_comb begin
        if (r_phacc[PHASE_W-1]) begin
            w_t = {1'b0, r_phacc[PHASE_W-2:0], 1'b0};
        end else begin
            w_t = (T_W'(1) << PHASE_W) - {r_phacc, 1'b0};
        end
        w_tb       = {1'b0, w_t} + (T_W + 1)'(128);
        w_bart     = WGT_W'(ONE_Q16) - WGT_W'(w_tb[T_W:8]);
        w_acc_init = ACC_W'({f_cos_a0(r_kind), 16'b0}) + ACC_W'(32768);
    end

    // Quarter-wave table address for the harmonic phase in r_cph
    always_comb begin
        w_quad     = r_cph[PHASE_W-1 -: 2];
        w_frac     = r_cph[FRAC_W-1:0];
        w_scaled   = SC_W'(w_frac) * SC_W'(COS_TABLE_DEPTH) + (SC_W'(1) << (FRAC_W - 1));
        w_idx      = w_scaled[SC_W-1:FRAC_W];
        w_mir      = IW'(COS_TABLE_DEPTH) - w_idx;
        w_sel      = w_quad[0] ? w_mir : w_idx;
        w_zero     = (w_sel >= IW'(COS_TABLE_DEPTH));
        w_rom_addr = w_sel[AW-1:0];
    end

    swa_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Apply the quadrant sign to the table word
    always_comb begin
        if (r_s1_zero) begin
            w_cos = '0;
        end else if (r_s1_neg) begin
            w_cos = -$signed({1'b0, w_rom_data});
        end else begin
            w_cos = $signed({1'b0, w_rom_data});
        end
    end

    // The one multiplier, steered by the sequencer
    always_comb begin
        unique case (r_state)
            S_TMUL: begin
                w_mul_a = MA'({1'b0, r_t});
                w_mul_b = (r_kind == WK_TRI) ? MB'({1'b0, r_tscale}) : MB'({1'b0, r_t});
            end
            S_COS: begin
                w_mul_a = MA'(f_cos_coef(r_kind, r_s1_k));
                w_mul_b = MB'(w_cos);
            end
            S_SMUL: begin
                w_mul_a = MA'(r_sample);
                w_mul_b = MB'(r_weight);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    // Weight and sample rounding from the registered product
    always_comb begin
        w_tsum = r_prod + (PW'(1) << 23);
        w_wsum = r_prod + (PW'(1) << 31);
        w_rsum = r_prod + PW'(32768);
        w_y    = w_rsum >>> Q_SH;
        if (w_y > SAT_HI_P) begin
            w_y_sat = OUT_HI;
        end else if (w_y < SAT_LO_P) begin
            w_y_sat = OUT_LO;
        end else begin
            w_y_sat = OW'(w_y);
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_flen       = r_flen;
        n_step       = r_step;
        n_tscale     = r_tscale;
        n_pos        = r_pos;
        n_phacc      = r_phacc;
        n_out_valid  = r_out_valid;
        n_iss        = r_iss;
        n_s1_v       = r_s1_v;
        n_s2_v       = r_s2_v;
        n_sample     = r_sample;
        n_t          = r_t;
        n_ph         = r_ph;
        n_cph        = r_cph;
        n_last       = r_last;
        n_s1_k       = r_s1_k;
        n_s1_neg     = r_s1_neg;
        n_s1_zero    = r_s1_zero;
        n_s2_k       = r_s2_k;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_weight     = r_weight;
        n_out_sample = r_out_sample;
        n_out_end    = r_out_end;

        if (w_cfg_fire) begin
            unique case (i_cfg.index)
                CFG_KIND:   n_kind   = i_cfg.data[KIND_W-1:0];
                CFG_LENGTH: n_flen   = i_cfg.data[FLEN_W-1:0];
                CFG_STEP:   n_step   = i_cfg.data[PHASE_W-1:0];
                CFG_TSCALE: n_tscale = i_cfg.data[TSCALE_W-1:0];
                default:    n_kind   = r_kind;
            endcase
        end

        // Drop the result once the receiver takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_sample = i_in.sample_in;
                    n_ph     = r_phacc;
                    n_cph    = r_phacc;
                    n_t      = w_t;
                    n_last   = w_last;
                    n_iss    = '0;
                    n_s1_v   = 1'b0;
                    n_s2_v   = 1'b0;
                    n_acc    = w_acc_init;
                    if (w_last) begin
                        n_pos   = '0;
                        n_phacc = '0;
                    end else begin
                        n_pos   = r_pos + POS_W'(1);
                        n_phacc = r_phacc + r_step;
                    end
                    unique case (r_kind)
                        WK_TRI, WK_WELCH: begin
                            n_state = S_TMUL;
                        end
                        WK_BARTLETT: begin
                            n_weight = w_bart;
                            n_state  = S_SMUL;
                        end
                        WK_HANN, WK_BLACKMAN, WK_EXACT, WK_NUTTALL,
                        WK_BL_NUTTALL, WK_BL_HARRIS, WK_FLATTOP: begin
                            n_state = S_COS;
                        end
                        default: begin
                            n_weight = WGT_W'(ONE_Q16);
                            n_state  = S_SMUL;
                        end
                    endcase
                end
            end
            S_TMUL: begin
                n_prod  = w_mul;
                n_state = S_TWGT;
            end
            S_TWGT: begin
                if (r_kind == WK_TRI) begin
                    n_weight = WGT_W'(ONE_Q16) - WGT_W'(w_tsum[24 +: COS_W]);
                end else begin
                    n_weight = WGT_W'(ONE_Q16) - WGT_W'(w_wsum[32 +: COS_W]);
                end
                n_state = S_SMUL;
            end
            S_COS: begin
                // Issue: one harmonic phase a cycle into the table
                if (r_iss < 3'(N_TERMS)) begin
                    n_cph     = r_cph + r_ph;
                    n_iss     = r_iss + 3'd1;
                    n_s1_v    = 1'b1;
                    n_s1_k    = r_iss[1:0];
                    n_s1_neg  = w_quad[0] ^ w_quad[1];
                    n_s1_zero = w_zero;
                end else begin
                    n_s1_v = 1'b0;
                end
                // Multiply: coefficient times signed cosine
                n_s2_v = r_s1_v;
                if (r_s1_v) begin
                    n_prod = w_mul;
                    n_s2_k = r_s1_k;
                end
                // Accumulate; the last harmonic closes the weight
                if (r_s2_v) begin
                    n_acc = r_acc + ACC_W'(r_prod);
                    if (r_s2_k == TERM_LAST) begin
                        n_weight = n_acc[Q_SH +: WGT_W];
                        n_state  = S_SMUL;
                    end
                end
            end
            S_SMUL: begin
                n_prod  = w_mul;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_y_sat;
                    n_out_end    = r_last;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= WK_PASS;
            r_flen      <= FLEN_W'(1024);
            r_step      <= PHASE_W'(16400);
            r_tscale    <= TSCALE_W'(65472);
            r_pos       <= '0;
            r_phacc     <= '0;
            r_out_valid <= 1'b0;
            r_iss       <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_flen      <= n_flen;
            r_step      <= n_step;
            r_tscale    <= n_tscale;
            r_pos       <= n_pos;
            r_phacc     <= n_phacc;
            r_out_valid <= n_out_valid;
            r_iss       <= n_iss;
            r_s1_v      <= n_s1_v;
            r_s2_v      <= n_s2_v;
        end
        r_sample     <= n_sample;
        r_t          <= n_t;
        r_ph         <= n_ph;
        r_cph        <= n_cph;
        r_last       <= n_last;
        r_s1_k       <= n_s1_k;
        r_s1_neg     <= n_s1_neg;
        r_s1_zero    <= n_s1_zero;
        r_s2_k       <= n_s2_k;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_weight     <= n_weight;
        r_out_sample <= n_out_sample;
        r_out_end    <= n_out_end;
    end

endmodule

`default_nettype wire

FILE: src/swa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module swa_checker #(
    parameter int OUT_W = 27
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [OUT_W-1:0] i_out_sample,
    input wire logic             i_out_end
);

    // A taken sample keeps the input closed for the next cycle
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready the cycle after a beat");

    // No result can rise in the cycle after its sample arrived
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared too soon after an input beat");

    // A stalled result stays offered
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_sample) && $stable(i_out_end)))
        else $error("result payload changed while stalled");

endmodule

bind spectral_window_applier swa_checker #(
    .OUT_W (SAMPLE_BITS + 3)
) u_swa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_end    (o_out.frame_end)
);

`default_nettype wire
